### rtl/pprd_pkg.sv
// shared types, constants and helpers for the pump packet record decoder
// used by pprd_parse, pprd_scale and pump_packet_record_decoder
package pprd_pkg;

    // configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_PRESSURE_GAIN   = 3'd0;
    localparam logic [2:0] REG_PRESSURE_OFFSET = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_GAIN    = 3'd2;
    localparam logic [2:0] REG_VOLTAGE_OFFSET  = 3'd3;
    localparam logic [2:0] REG_CURRENT_GAIN    = 3'd4;
    localparam logic [2:0] REG_CURRENT_OFFSET  = 3'd5;

    localparam logic [31:0] GAIN_RESET   = 32'h0001_0000;
    localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;

    localparam logic [3:0]  FORMAT_V1     = 4'd1;
    localparam logic [11:0] HDR_LEN_V1    = 12'd10;
    localparam logic [11:0] HDR_LEN_OTHER = 12'd6;
    localparam logic [3:0]  REC_LEN_V1    = 4'd14;
    localparam logic [3:0]  REC_LEN_OTHER = 4'd11;
    localparam logic [11:0] OFFSET_MAX    = 12'd4095;
    localparam logic [11:0] OFF_VERSION   = 12'd1;
    localparam logic [11:0] OFF_LENGTH_LO = 12'd2;
    localparam logic [15:0] PUMP_TIME_MID = 16'h8000;
    localparam int          RecBytes      = 14;

    // one decoded record before scaling
    typedef struct packed {
        logic [3:0]  packet_number;
        logic [3:0]  phase;
        logic [19:0] pressure_count;
        logic [16:0] run_time;
        logic [15:0] voltage_count;
        logic [15:0] current_count;
        logic [7:0]  vacuum_start;
        logic [7:0]  vacuum_end;
        logic [32:0] sample_seconds;
    } rec_t;

    // load enables of the two scaling stages
    typedef struct packed {
        logic mul_load;
        logic out_load;
    } pipe_ctrl_t;

    // clamp a 54-bit signed value to the 48-bit signed range
    function automatic logic [47:0] sat48(input logic [53:0] v);
        logic fits;
        fits = (v[53:47] == 7'h00) || (v[53:47] == 7'h7F);
        if (fits) begin
            sat48 = v[47:0];
        end else if (v[53]) begin
            sat48 = {1'b1, 47'h0};
        end else begin
            sat48 = {1'b0, {47{1'b1}}};
        end
    endfunction

endpackage

### rtl/pump_packet_record_decoder.sv
// top level of the pump packet record decoder: stream ports, register file,
// parser and three scaling channels; depends on pprd_pkg, pprd_parse, pprd_scale
//
//  channel   direction  payload
//  s_*       in         tdata: packet_byte; tuser: packet_start
//  m_*       out        tdata: one decoded record (270 bits + 2 pad)
//  apb       in         six 32-bit scaling registers at 0x00..0x14
//
// one byte is accepted per cycle while s_tready is high; m_tvalid rises once the
// last byte of a record has passed the assembly, multiplier and result registers
// s_tready drops only when all three stages hold records and m_tready is low
// aresetn clears the parser and the stage valid bits and resets the scaling registers
module pump_packet_record_decoder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] packet_byte
    input  logic [0:0]    s_tuser,   // [0] packet_start
    output logic          m_tvalid,
    input  logic          m_tready,
    // [3:0] packet_number, [7:4] phase, [27:8] pressure_count, [75:28] pressure,
    // [92:76] run_time, [108:93] voltage_count, [156:109] voltage,
    // [172:157] current_count, [220:173] current, [228:221] vacuum_start,
    // [236:229] vacuum_end, [269:237] sample_seconds, [271:270] zero
    output logic [271:0]  m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0] pressure_gain_reg, pressure_offset_reg;
    logic [31:0] voltage_gain_reg, voltage_offset_reg;
    logic [31:0] current_gain_reg, current_offset_reg;
    logic        cfg_write;

    logic                 rec_valid;
    pprd_pkg::rec_t       rec;
    pprd_pkg::rec_t       mul_rec_reg, out_rec_reg;
    logic                 mul_valid_reg, out_valid_reg;
    pprd_pkg::pipe_ctrl_t ctrl;
    logic                 rec_take;
    logic [47:0]          pressure, voltage, current;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_gain_reg   <= pprd_pkg::GAIN_RESET;
            pressure_offset_reg <= pprd_pkg::OFFSET_RESET;
            voltage_gain_reg    <= pprd_pkg::GAIN_RESET;
            voltage_offset_reg  <= pprd_pkg::OFFSET_RESET;
            current_gain_reg    <= pprd_pkg::GAIN_RESET;
            current_offset_reg  <= pprd_pkg::OFFSET_RESET;
        end else if (cfg_write) begin
            case (paddr[4:2])
                pprd_pkg::REG_PRESSURE_GAIN:   pressure_gain_reg   <= pwdata;
                pprd_pkg::REG_PRESSURE_OFFSET: pressure_offset_reg <= pwdata;
                pprd_pkg::REG_VOLTAGE_GAIN:    voltage_gain_reg    <= pwdata;
                pprd_pkg::REG_VOLTAGE_OFFSET:  voltage_offset_reg  <= pwdata;
                pprd_pkg::REG_CURRENT_GAIN:    current_gain_reg    <= pwdata;
                pprd_pkg::REG_CURRENT_OFFSET:  current_offset_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            pprd_pkg::REG_PRESSURE_GAIN:   prdata = pressure_gain_reg;
            pprd_pkg::REG_PRESSURE_OFFSET: prdata = pressure_offset_reg;
            pprd_pkg::REG_VOLTAGE_GAIN:    prdata = voltage_gain_reg;
            pprd_pkg::REG_VOLTAGE_OFFSET:  prdata = voltage_offset_reg;
            pprd_pkg::REG_CURRENT_GAIN:    prdata = current_gain_reg;
            pprd_pkg::REG_CURRENT_OFFSET:  prdata = current_offset_reg;
            default:                       prdata = 32'd0;
        endcase
    end

    // stage flow: each stage loads when empty or when its content moves on
    assign ctrl.out_load = !out_valid_reg || m_tready;
    assign ctrl.mul_load = !mul_valid_reg || ctrl.out_load;
    assign rec_take      = ctrl.mul_load;
    assign s_tready      = !rec_valid || ctrl.mul_load;

    pprd_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (s_tvalid && s_tready),
        .packet_byte  (s_tdata),
        .packet_start (s_tuser[0]),
        .rec_take     (rec_take),
        .rec_valid    (rec_valid),
        .rec          (rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.mul_load) begin
                mul_valid_reg <= rec_valid;
            end
            if (ctrl.out_load) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_load) begin
            mul_rec_reg <= rec;
        end
        if (ctrl.out_load) begin
            out_rec_reg <= mul_rec_reg;
        end
    end

    pprd_scale u_pressure (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .count  (rec.pressure_count),
        .gain   (pressure_gain_reg),
        .offset (pressure_offset_reg),
        .result (pressure)
    );

    pprd_scale u_voltage (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .count  ({4'd0, rec.voltage_count}),
        .gain   (voltage_gain_reg),
        .offset (voltage_offset_reg),
        .result (voltage)
    );

    pprd_scale u_current (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .count  ({4'd0, rec.current_count}),
        .gain   (current_gain_reg),
        .offset (current_offset_reg),
        .result (current)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_rec_reg.sample_seconds,
                       out_rec_reg.vacuum_end,
                       out_rec_reg.vacuum_start,
                       current,
                       out_rec_reg.current_count,
                       voltage,
                       out_rec_reg.voltage_count,
                       out_rec_reg.run_time,
                       pressure,
                       out_rec_reg.pressure_count,
                       out_rec_reg.phase,
                       out_rec_reg.packet_number};

endmodule

### rtl/pprd_parse.sv
// byte parser: header capture, record byte store and record assembly
// depends on pprd_pkg
module pprd_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_accept,
    input  logic [7:0]          packet_byte,
    input  logic                packet_start,
    input  logic                rec_take,
    output logic                rec_valid,
    output pprd_pkg::rec_t      rec
);

    logic [11:0] byte_offset_reg, byte_offset_next;
    logic [11:0] packet_length_reg, packet_length_next;
    logic [3:0]  format_version_reg, format_version_next;
    logic [3:0]  packet_id_reg, packet_id_next;
    logic [31:0] start_seconds_reg, start_seconds_next;
    logic [3:0]  record_offset_reg, record_offset_next;
    logic        packet_done_reg, packet_done_next;
    logic [7:0]  record_bytes_reg [pprd_pkg::RecBytes];
    logic        rec_valid_reg, rec_valid_next;
    pprd_pkg::rec_t rec_reg, rec_next;

    logic [7:0]  rb [pprd_pkg::RecBytes];
    logic [11:0] hdr_len;
    logic [3:0]  rec_len;
    logic        store_byte;
    logic        emit;
    logic [15:0] pt;
    logic        is_v1;

    // record bytes as they stand once the current byte is in
    always_comb begin
        for (int i = 0; i < pprd_pkg::RecBytes; i++) begin
            rb[i] = (record_offset_reg == 4'(i)) ? packet_byte : record_bytes_reg[i];
        end
    end

    assign is_v1   = (format_version_reg == pprd_pkg::FORMAT_V1);
    assign hdr_len = is_v1 ? pprd_pkg::HDR_LEN_V1 : pprd_pkg::HDR_LEN_OTHER;
    assign rec_len = is_v1 ? pprd_pkg::REC_LEN_V1 : pprd_pkg::REC_LEN_OTHER;
    assign pt      = {rb[3], rb[4]};

    always_comb begin
        byte_offset_next    = byte_offset_reg;
        packet_length_next  = packet_length_reg;
        format_version_next = format_version_reg;
        packet_id_next      = packet_id_reg;
        start_seconds_next  = start_seconds_reg;
        record_offset_next  = record_offset_reg;
        packet_done_next    = packet_done_reg;
        store_byte          = 1'b0;
        emit                = 1'b0;

        if (byte_accept) begin
            if (packet_start) begin
                packet_id_next      = packet_byte[3:0];
                byte_offset_next    = 12'd1;
                record_offset_next  = 4'd0;
                packet_length_next  = 12'd0;
                format_version_next = 4'd0;
                start_seconds_next  = 32'd0;
                packet_done_next    = 1'b0;
            end else if (!packet_done_reg) begin
                if (byte_offset_reg != pprd_pkg::OFFSET_MAX) begin
                    byte_offset_next = byte_offset_reg + 12'd1;
                end
                if (byte_offset_reg < hdr_len) begin
                    if (byte_offset_reg == pprd_pkg::OFF_VERSION) begin
                        format_version_next = packet_byte[7:4];
                        packet_length_next  = {packet_byte[3:0], packet_length_reg[7:0]};
                    end else if (byte_offset_reg == pprd_pkg::OFF_LENGTH_LO) begin
                        packet_length_next  = {packet_length_reg[11:8], packet_byte};
                    end else if (byte_offset_reg >= pprd_pkg::HDR_LEN_OTHER) begin
                        start_seconds_next  = {start_seconds_reg[23:0], packet_byte};
                    end
                end else if (record_offset_reg == 4'd0 &&
                             (packet_length_reg < 12'd2 ||
                              byte_offset_reg >= packet_length_reg - 12'd1)) begin
                    packet_done_next = 1'b1;
                end else begin
                    store_byte = 1'b1;
                    if (record_offset_reg + 4'd1 == rec_len) begin
                        record_offset_next = 4'd0;
                        emit               = 1'b1;
                    end else begin
                        record_offset_next = record_offset_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        rec_next                = rec_reg;
        rec_valid_next          = rec_valid_reg;
        if (rec_take) begin
            rec_valid_next = 1'b0;
        end
        if (emit) begin
            rec_valid_next              = 1'b1;
            rec_next.packet_number      = packet_id_reg;
            rec_next.phase              = rb[0][7:4];
            rec_next.pressure_count     = {rb[0][3:0], rb[1], rb[2]};
            rec_next.run_time           = {(pt > pprd_pkg::PUMP_TIME_MID), pt};
            rec_next.voltage_count      = {rb[5], rb[6]};
            rec_next.current_count      = {rb[7], rb[8]};
            rec_next.vacuum_start       = rb[9];
            rec_next.vacuum_end         = rb[10];
            rec_next.sample_seconds     = is_v1 ?
                ({1'b0, start_seconds_reg} + {9'd0, rb[11], rb[12], rb[13]}) : 33'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg    <= 12'd0;
            packet_length_reg  <= 12'd0;
            format_version_reg <= 4'd0;
            packet_id_reg      <= 4'd0;
            start_seconds_reg  <= 32'd0;
            record_offset_reg  <= 4'd0;
            packet_done_reg    <= 1'b1;
            rec_valid_reg      <= 1'b0;
        end else begin
            byte_offset_reg    <= byte_offset_next;
            packet_length_reg  <= packet_length_next;
            format_version_reg <= format_version_next;
            packet_id_reg      <= packet_id_next;
            start_seconds_reg  <= start_seconds_next;
            record_offset_reg  <= record_offset_next;
            packet_done_reg    <= packet_done_next;
            rec_valid_reg      <= rec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        if (store_byte) begin
            record_bytes_reg[record_offset_reg] <= packet_byte;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

### rtl/pprd_scale.sv
// one scaling channel: registered count*gain, then subtract offset and saturate
// depends on pprd_pkg
module pprd_scale (
    input  logic                 aclk,
    input  pprd_pkg::pipe_ctrl_t ctrl,
    input  logic [19:0]          count,
    input  logic [31:0]          gain,
    input  logic [31:0]          offset,
    output logic [47:0]          result
);

    logic signed [52:0] prod_reg, prod_next;
    logic [47:0]        result_reg, result_next;
    logic [53:0]        diff;

    assign prod_next   = $signed({1'b0, count}) * $signed(gain);
    assign diff        = 54'($signed({prod_reg[52], prod_reg}) -
                             $signed({{22{offset[31]}}, offset}));
    assign result_next = pprd_pkg::sat48(diff);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_load) begin
            prod_reg <= prod_next;
        end
        if (ctrl.out_load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
